### sv/hcs_pkg.sv
// Package for the shortened Hamming codec: field widths, request kinds,
// register indexes, check masks and the information-bit position table.
// No dependencies.
package hcs_pkg;

  localparam int unsigned DataW  = 31;
  localparam int unsigned InfoW  = 26;
  localparam int unsigned SynW   = 5;
  localparam int unsigned LenW   = 5;
  localparam int unsigned AddrW  = 3;

  typedef enum logic {
    REQ_ENCODE = 1'b0,
    REQ_DECODE = 1'b1
  } req_t;

  // register indexes (paddr[2])
  typedef enum logic {
    REG_CODE_LENGTH    = 1'b0,
    REG_PARITY_ENABLED = 1'b1
  } reg_idx_t;

  localparam logic [LenW-1:0] LEN_MIN      = 5'd3;
  localparam logic [LenW-1:0] LEN_MIN_PAR  = 5'd5;
  localparam logic [LenW-1:0] LEN_RESET    = 5'd7;

  // bit k-1 set when position k has check index bit i set
  localparam logic [DataW-1:0] CHK_MASK [SynW] = '{
    31'h5555_5555,
    31'h6666_6666,
    31'h7878_7878,
    31'h7F80_7F80,
    31'h7FFF_8000
  };

  // bit index of the j-th position that is not a power of two
  localparam logic [LenW-1:0] INFO_POS [InfoW] = '{
    5'd2,  5'd4,  5'd5,  5'd6,  5'd8,  5'd9,  5'd10, 5'd11, 5'd12,
    5'd13, 5'd14, 5'd16, 5'd17, 5'd18, 5'd19, 5'd20, 5'd21, 5'd22,
    5'd23, 5'd24, 5'd25, 5'd26, 5'd27, 5'd28, 5'd29, 5'd30
  };

  typedef struct packed {
    logic               bit_corrected;
    logic               parity_check;
    logic [SynW-1:0]    syndrome;
    logic [InfoW-1:0]   info_word;
    logic [DataW-1:0]   code_word;
  } hcs_result_t;

endpackage

### sv/hamming_codec_shortened.sv
// Top level of the shortened Hamming codec: stream channels, APB registers,
// input and result registers around hcs_core. Depends on hcs_pkg, hcs_core.
//
// Usage:
//   Input stream: in_tuser = request kind (0 encode, 1 decode), in_tdata[30:0]
//   = information word or received codeword, bit 0 first.
//   Result stream: out_tdata packs code_word, info_word, syndrome,
//   parity_check and bit_corrected from bit 0 up (64 bits).
//   Registers: code_length at byte 0x0, parity_enabled at byte 0x4; write
//   them only while no transaction is in flight. Lengths below 3 act as 3;
//   parity is ignored for lengths below 5.
// Pipeline: two register stages, the input register and the result register
//   (drives out_tvalid), with the XOR trees of hcs_core between them.
// Throughput: one transaction per cycle while out_tready is high.
// Reset: rst_n low clears both stages' valid flags and sets code_length to 7,
//   parity off.
// Stall: when out_tready is low the result register holds; the input stage
//   still takes one more transaction, then in_tready drops until the
//   receiver takes the pending result.
module hamming_codec_shortened (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [31:0]                 in_tdata,   // [30:0] data_word
  input  logic                        in_tuser,   // [0] req_type
  // result channel
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [63:0]                 out_tdata,  // [30:0] code_word,
                                                  // [56:31] info_word,
                                                  // [61:57] syndrome,
                                                  // [62] parity_check,
                                                  // [63] bit_corrected
  // configuration port
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [hcs_pkg::AddrW-1:0]   cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import hcs_pkg::*;

  logic [LenW-1:0]   code_length_r;
  logic              parity_enabled_r;
  logic              s1_valid_r;
  req_t              s1_req_r;
  logic [DataW-1:0]  s1_data_r;
  logic              out_valid_r;
  hcs_result_t       out_res_r;
  hcs_result_t       core_res;
  reg_idx_t          reg_idx;
  logic              cfg_wr;
  logic              out_free;
  logic              s1_adv;
  logic              in_acc;

  // configuration registers
  assign cfg_pready = 1'b1;
  assign reg_idx    = reg_idx_t'(cfg_paddr[2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_length_r    <= LEN_RESET;
      parity_enabled_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_CODE_LENGTH:    code_length_r    <= cfg_pwdata[LenW-1:0];
        REG_PARITY_ENABLED: parity_enabled_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_idx)
      REG_CODE_LENGTH:    cfg_prdata = {{(32-LenW){1'b0}}, code_length_r};
      REG_PARITY_ENABLED: cfg_prdata = {31'd0, parity_enabled_r};
      default:            cfg_prdata = '0;
    endcase
  end

  // stage handshake
  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_acc    = in_tvalid && in_tready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r  <= req_t'(in_tuser);
      s1_data_r <= in_tdata[DataW-1:0];
    end
  end

  hcs_core u_core (
    .req_type       (s1_req_r),
    .data_word      (s1_data_r),
    .code_length    (code_length_r),
    .parity_enabled (parity_enabled_r),
    .result         (core_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= core_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r;

`ifndef SYNTHESIS
  // a correction always comes with a nonzero syndrome
  a_fix_has_syn: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[63] |-> out_tdata[61:57] != 5'd0)
    else $error("correction flagged with zero syndrome");

  // an encode transaction yields no syndrome and no correction
  a_enc_clean: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && (s1_req_r == REQ_ENCODE) |=>
      (out_tdata[61:57] == 5'd0) && !out_tdata[63] && !out_tdata[62])
    else $error("encode result carries decode status");

  // an accepted transaction is held in the input stage
  a_in_capture: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("input transaction lost");

  // a stalled input stage keeps its word
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_free |=> s1_valid_r && $stable(s1_data_r))
    else $error("input stage changed while stalled");

  // a result moves into the output register only when it is free
  a_out_move: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("result dropped");
`endif

endmodule

### sv/hcs_core.sv
// Combinational encode/decode datapath of the shortened Hamming codec.
// Depends on hcs_pkg.
module hcs_core (
  input  hcs_pkg::req_t               req_type,
  input  logic [hcs_pkg::DataW-1:0]   data_word,
  input  logic [hcs_pkg::LenW-1:0]    code_length,
  input  logic                        parity_enabled,
  output hcs_pkg::hcs_result_t        result
);
  import hcs_pkg::*;

  logic [LenW-1:0]  n_len;
  logic             par;
  logic [LenW-1:0]  h_len;
  logic [LenW-1:0]  r_cnt;
  logic [LenW-1:0]  k_len;
  logic [DataW-1:0] mask_n;
  logic [DataW-1:0] mask_h;
  logic [InfoW-1:0] mask_k;
  logic [InfoW-1:0] info_e;
  logic [DataW-1:0] cw_place;
  logic [DataW-1:0] cw_chk;
  logic [DataW-1:0] cw_enc;
  logic [DataW-1:0] cw_n;
  logic [DataW-1:0] cw_h;
  logic [SynW-1:0]  syn;
  logic             fix;
  logic [DataW-1:0] cw_dec;
  logic [DataW-1:0] cw_dec_h;
  logic [InfoW-1:0] info_d;

  // clamp length, resolve parity and Hamming sizes
  always_comb begin
    n_len = (code_length < LEN_MIN) ? LEN_MIN : code_length;
    par   = parity_enabled && (n_len >= LEN_MIN_PAR);
    h_len = n_len - {{(LenW-1){1'b0}}, par};
    priority if (h_len <= 5'd3) begin
      r_cnt = 5'd2;
    end else if (h_len <= 5'd7) begin
      r_cnt = 5'd3;
    end else if (h_len <= 5'd15) begin
      r_cnt = 5'd4;
    end else begin
      r_cnt = 5'd5;
    end
    k_len  = h_len - r_cnt;
    mask_n = {DataW{1'b1}} >> (5'd31 - n_len);
    mask_h = {DataW{1'b1}} >> (5'd31 - h_len);
    mask_k = {InfoW{1'b1}} >> (5'd26 - k_len);
  end

  // encode: scatter info bits, add check bits, then overall parity
  always_comb begin
    info_e   = data_word[InfoW-1:0] & mask_k;
    cw_place = '0;
    for (int j = 0; j < InfoW; j++) begin
      cw_place[INFO_POS[j]] = info_e[j];
    end
    cw_chk = cw_place;
    for (int i = 0; i < SynW; i++) begin
      cw_chk[(1 << i) - 1] = ^(cw_place & CHK_MASK[i]);
    end
    cw_enc = cw_chk | ({{(DataW-1){1'b0}}, par & (^cw_chk)} << (n_len - 5'd1));
  end

  // decode: syndrome over Hamming part, correct, gather info bits
  always_comb begin
    cw_n = data_word & mask_n;
    cw_h = data_word & mask_h;
    for (int i = 0; i < SynW; i++) begin
      syn[i] = ^(cw_h & CHK_MASK[i]);
    end
    fix      = (syn != '0) && (syn <= h_len);
    cw_dec   = cw_n ^ ({{(DataW-1){1'b0}}, fix} << (syn - 5'd1));
    cw_dec_h = cw_dec & mask_h;
    for (int j = 0; j < InfoW; j++) begin
      info_d[j] = cw_dec_h[INFO_POS[j]];
    end
  end

  // select result by request kind
  always_comb begin
    unique case (req_type)
      REQ_ENCODE: begin
        result.code_word     = cw_enc;
        result.info_word     = info_e;
        result.syndrome      = '0;
        result.parity_check  = 1'b0;
        result.bit_corrected = 1'b0;
      end
      REQ_DECODE: begin
        result.code_word     = cw_dec;
        result.info_word     = info_d;
        result.syndrome      = syn;
        result.parity_check  = par & (^cw_n);
        result.bit_corrected = fix;
      end
      default: begin
        result = '0;
      end
    endcase
  end

endmodule

### test/tb_hamming_codec_shortened.sv
// Testbench for hamming_codec_shortened: directed and random encode/decode
// traffic under several code lengths, checked against an in-bench predictor.
// Depends on hcs_pkg and the hamming_codec_shortened RTL.
`timescale 1ns / 1ps

module tb_hamming_codec_shortened;
  import hcs_pkg::*;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;     // [30:0] data_word
  logic        in_tuser = 1'b0;   // [0] req_type
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;         // [30:0] code_word, [56:31] info_word,
                                  // [61:57] syndrome, [62] parity_check,
                                  // [63] bit_corrected
  logic             cfg_psel = 1'b0;
  logic             cfg_penable = 1'b0;
  logic             cfg_pwrite = 1'b0;
  logic [AddrW-1:0] cfg_paddr = '0;
  logic [31:0]      cfg_pwdata = '0;
  logic [31:0]      cfg_prdata;
  logic             cfg_pready;

  // bench copy of the configuration registers
  logic [LenW-1:0] cur_length = LEN_RESET;
  logic            cur_parity = 1'b0;

  hcs_result_t expected_words[$];
  int          error_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          stall_request = 1'b0;
  int          stall_left = 0;

  hamming_codec_shortened i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // XOR of positions 1..h whose index has bit i set
  function automatic logic check_group(logic [DataW-1:0] word, int unsigned h,
                                       int unsigned i);
    logic acc;
    acc = 1'b0;
    for (int unsigned p = 1; p <= h; p++) begin
      if ((p >> i) & 1) acc ^= word[p-1];
    end
    return acc;
  endfunction

  // expected result of one request under the given register settings
  function automatic hcs_result_t hamming_result(req_t kind, logic [DataW-1:0] word,
                                                 logic [LenW-1:0] len_reg,
                                                 logic par_reg);
    int unsigned n, h, r, k, j;
    logic        par;
    hcs_result_t res;
    n = len_reg;
    if (n < LEN_MIN) n = LEN_MIN;
    par = par_reg && (n >= LEN_MIN_PAR);
    h = n - par;
    r = 0;
    while ((1 << r) < h + 1) r++;
    k = h - r;
    res = '0;
    if (kind == REQ_ENCODE) begin
      for (int unsigned b = 0; b < k; b++) res.info_word[b] = word[b];
      j = 0;
      for (int unsigned p = 1; p <= h; p++) begin
        if ((p & (p - 1)) != 0) begin
          res.code_word[p-1] = res.info_word[j];
          j++;
        end
      end
      for (int unsigned i = 0; i < r; i++)
        res.code_word[(1 << i) - 1] = check_group(res.code_word, h, i);
      if (par) res.code_word[n-1] = ^res.code_word;
    end else begin
      for (int unsigned b = 0; b < n; b++) res.code_word[b] = word[b];
      for (int unsigned i = 0; i < r; i++)
        res.syndrome[i] = check_group(res.code_word, h, i);
      if (par) res.parity_check = ^res.code_word;
      // flip only for a nonzero syndrome inside the Hamming part
      if (res.syndrome != 0 && res.syndrome <= h) begin
        res.code_word[res.syndrome-1] = ~res.code_word[res.syndrome-1];
        res.bit_corrected = 1'b1;
      end
      j = 0;
      for (int unsigned p = 1; p <= h; p++) begin
        if ((p & (p - 1)) != 0) begin
          res.info_word[j] = res.code_word[p-1];
          j++;
        end
      end
    end
    return res;
  endfunction

  // receiver: random backpressure, or a long hold-off on request
  always @(posedge clk) begin
    if (stall_request) begin
      stall_left = 60;
      stall_request = 1'b0;
    end
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic compare_field(string name, logic [DataW-1:0] want, logic [DataW-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    hcs_result_t got;
    hcs_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = hcs_result_t'(out_tdata);
      if (expected_words.size() == 0) begin
        $error("result transaction with no request pending: 0x%0h", out_tdata);
        error_count++;
      end else begin
        want = expected_words.pop_front();
        compare_field("code_word", want.code_word, got.code_word);
        compare_field("info_word", DataW'(want.info_word), DataW'(got.info_word));
        compare_field("syndrome", DataW'(want.syndrome), DataW'(got.syndrome));
        compare_field("parity_check", DataW'(want.parity_check),
                      DataW'(got.parity_check));
        compare_field("bit_corrected", DataW'(want.bit_corrected),
                      DataW'(got.bit_corrected));
      end
    end
  end

  // offer one request; return at the edge that accepts it
  task automatic send_request(req_t kind, logic [DataW-1:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, word};
    in_tuser  <= kind;
    do @(posedge clk); while (!in_tready);
    expected_words.push_back(hamming_result(kind, word, cur_length, cur_parity));
  endtask

  // decode a valid codeword of info under the current settings, with bits flipped
  task automatic send_corrupted(logic [DataW-1:0] info, logic [DataW-1:0] flips);
    hcs_result_t enc;
    enc = hamming_result(REQ_ENCODE, info, cur_length, cur_parity);
    send_request(REQ_DECODE, enc.code_word ^ flips);
  endtask

  // drop valid and drain all pending results, then cover the pipeline latency
  task automatic wait_idle();
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    while (expected_words.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    if (expected_words.size() != 0) begin
      $error("%0d expected results never arrived", expected_words.size());
      error_count++;
      expected_words.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  // APB access: setup cycle, then access cycle until pready
  task automatic apb_access(reg_idx_t idx, logic write, logic [31:0] wdata,
                            output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic read_check(reg_idx_t idx, logic [31:0] want);
    logic [31:0] rdata;
    apb_access(idx, 1'b0, '0, rdata);
    if (rdata !== want) begin
      $error("register %s readback: expected 0x%0h, actual 0x%0h", idx.name(), want, rdata);
      error_count++;
    end
  endtask

  // write code length and parity enable, then read both back
  task automatic program_code(logic [LenW-1:0] len, logic par);
    logic [31:0] unused;
    apb_access(REG_CODE_LENGTH, 1'b1, 32'(len), unused);
    apb_access(REG_PARITY_ENABLED, 1'b1, 32'(par), unused);
    cur_length = len;
    cur_parity = par;
    read_check(REG_CODE_LENGTH, 32'(len));
    read_check(REG_PARITY_ENABLED, 32'(par));
  endtask

  // reset settings: length 7, no parity
  task automatic test_reset_settings();
    read_check(REG_CODE_LENGTH, 32'(LEN_RESET));
    read_check(REG_PARITY_ENABLED, 32'd0);
    send_request(REQ_ENCODE, 31'h0);
    send_request(REQ_ENCODE, 31'h7FFF_FFFF);
    send_request(REQ_DECODE, 31'h7FFF_FFFF);
    send_corrupted(31'hB, 31'h0);
    send_corrupted(31'hA, 31'h1 << 4);
    wait_idle();
  endtask

  // longest code, with and without the overall parity bit
  task automatic test_long_code();
    program_code(5'd31, 1'b1);
    send_request(REQ_ENCODE, 31'h7FFF_FFFF);
    send_corrupted(31'h2AA_AAAA, 31'h1 << 30);      // error on the parity bit
    send_request(REQ_DECODE, 31'h0000_C000);       // syndrome 31, beyond h = 30
    send_corrupted(31'h3FF_FFFF, 31'h1 << 29);      // last Hamming position
    wait_idle();
    program_code(5'd31, 1'b0);
    send_request(REQ_ENCODE, 31'h7FFF_FFFF);
    send_corrupted(31'h155_5555, 31'h1 << 30);      // syndrome 31, corrected
    wait_idle();
  endtask

  // lengths below the minimum, and parity on codes too short for it
  task automatic test_short_codes();
    program_code(5'd0, 1'b0);
    send_request(REQ_ENCODE, 31'h7FFF_FFFF);
    send_request(REQ_DECODE, 31'h5);
    wait_idle();
    program_code(5'd2, 1'b1);
    send_request(REQ_ENCODE, 31'h1);
    wait_idle();
    program_code(5'd4, 1'b1);
    send_request(REQ_ENCODE, 31'h1);
    send_corrupted(31'h1, 31'h1 << 3);
    wait_idle();
    program_code(5'd5, 1'b1);
    send_request(REQ_ENCODE, 31'h3);
    send_corrupted(31'h2, 31'h3);                  // double error
    wait_idle();
    program_code(5'd5, 1'b0);
    send_request(REQ_DECODE, 31'd12);              // syndrome 7, beyond h = 5
    wait_idle();
  endtask

  // hold off the receiver while the sender keeps offering back to back
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_code(5'd31, 1'b1);
    stall_request = 1'b1;
    for (int i = 0; i < 20; i++) send_request(REQ_ENCODE, 31'($urandom));
    wait_idle();
  endtask

  // random traffic: encodes, and decodes of mostly 0..2-error codewords or noise
  task automatic test_random_traffic(int send_pct, int recv_pct, int items);
    int          sent;
    int          chunk;
    int          sel;
    int          top;
    logic [4:0]  len;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(3))
        0: len = 5'd3;
        1: len = 5'd31;
        default: len = 5'($urandom_range(31));
      endcase
      program_code(len, 1'($urandom_range(1)));
      top = (cur_length < LEN_MIN) ? 2 : cur_length - 1;
      chunk = $urandom_range(30, 70);
      if (chunk > items - sent) chunk = items - sent;
      for (int i = 0; i < chunk; i++) begin
        sel = $urandom_range(9);
        if ($urandom_range(2) == 0) begin
          send_request(REQ_ENCODE, 31'($urandom));
        end else if (sel < 2) begin
          send_request(REQ_DECODE, 31'($urandom));
        end else if (sel < 4) begin
          send_corrupted(31'($urandom), 31'h0);
        end else if (sel < 8) begin
          send_corrupted(31'($urandom), 31'h1 << $urandom_range(top));
        end else begin
          send_corrupted(31'($urandom),
                         (31'h1 << $urandom_range(top)) ^ (31'h1 << $urandom_range(top)));
        end
      end
      sent += chunk;
      wait_idle();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_settings();
    test_long_code();
    test_short_codes();
    test_random_traffic(13, 78, 250);
    test_backpressure();
    test_random_traffic(78, 13, 250);
    test_random_traffic(0, 0, 250);
    wait_idle();
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
sv/hcs_pkg.sv
sv/hcs_core.sv
sv/hamming_codec_shortened.sv
test/tb_hamming_codec_shortened.sv
